// File: sv/tpaac_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tpaac_pkg
// Shared types, constants and helpers for the two-piece affine alignment cell.
// ============================================================================
package tpaac_pkg;

   // Widths of the scoring datapath
   localparam int unsigned SCORE_BITS    = 16;
   localparam int unsigned SUM_BITS      = SCORE_BITS + 2;  // score + two 8-bit terms
   localparam int unsigned IDX_BITS      = 10;
   localparam int unsigned SYM_BITS      = 8;
   localparam int unsigned CSR_DATA_BITS = 8;
   localparam int unsigned CSR_IDX_BITS  = 3;

   // Matrix extents; stored positions clamp to the last valid one
   localparam int unsigned MAX_QUERY_LEN = 1024;
   localparam int unsigned MAX_REF_LEN   = 1024;

   typedef logic signed [SCORE_BITS-1:0]    score_type;
   typedef logic signed [SUM_BITS-1:0]      sum_type;
   typedef logic signed [CSR_DATA_BITS-1:0] weight_type;
   typedef logic        [IDX_BITS-1:0]      idx_type;

   localparam score_type SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam score_type SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

   // Commands
   typedef enum logic [1:0] {
      CMD_COMPUTE     = 2'd0,
      CMD_UPDATE_BEST = 2'd1,
      CMD_CLEAR_BEST  = 2'd2,
      CMD_RESERVED    = 2'd3
   } cmd_type;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MATCH          = 3'd0,
      CSR_MISMATCH       = 3'd1,
      CSR_SHORT_STEP     = 3'd2,
      CSR_SHORT_OPEN     = 3'd3,
      CSR_LONG_STEP      = 3'd4,
      CSR_LONG_OPEN      = 3'd5
   } csr_index_type;

   // Traceback code fields
   localparam logic [1:0] TRACE_LEFT = 2'd1;
   localparam logic [1:0] TRACE_DIAG = 2'd2;
   localparam logic [1:0] TRACE_UP   = 2'd3;
   localparam int unsigned TRACE_IEXT_BIT = 2;
   localparam int unsigned TRACE_DEXT_BIT = 3;

   // Register reset values
   localparam weight_type MATCH_RESET      = 8'sd2;
   localparam weight_type MISMATCH_RESET   = -8'sd4;
   localparam weight_type SHORT_STEP_RESET = -8'sd2;
   localparam weight_type SHORT_OPEN_RESET = -8'sd4;
   localparam weight_type LONG_STEP_RESET  = -8'sd1;
   localparam weight_type LONG_OPEN_RESET  = -8'sd24;

   typedef struct packed {
      weight_type match_score;
      weight_type mismatch_score;
      weight_type short_gap_step;
      weight_type short_gap_open_extra;
      weight_type long_gap_step;
      weight_type long_gap_open_extra;
   } cfg_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic [SYM_BITS-1:0] query_symbol;
      logic [SYM_BITS-1:0] reference_symbol;
      score_type     left_insert;
      score_type     left_match;
      score_type     left_long_insert;
      score_type     up_match;
      score_type     up_delete;
      score_type     up_long_delete;
      score_type     diag_match;
      idx_type       row_index;
      idx_type       col_index;
   } req_type;

   typedef struct packed {
      score_type     insert_score;
      score_type     match_layer_score;
      score_type     delete_score;
      score_type     long_insert_score;
      score_type     long_delete_score;
      logic [3:0]    trace_code;
      score_type     best_score;
      idx_type       best_row;
      idx_type       best_col;
   } rsp_type;

   // Best-score tracker state
   typedef struct packed {
      score_type value;
      idx_type   row;
      idx_type   col;
   } best_type;

   // Full-precision sum of a score and two 8-bit terms
   function automatic sum_type add3(score_type a, weight_type b, weight_type c);
      return SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
   endfunction

   // Clamp a widened sum back into the score range
   function automatic score_type sat_score(sum_type v);
      logic ovf;
      ovf = (v[SUM_BITS-1:SCORE_BITS-1] != {(SUM_BITS-SCORE_BITS+1){1'b0}}) &&
            (v[SUM_BITS-1:SCORE_BITS-1] != {(SUM_BITS-SCORE_BITS+1){1'b1}});
      if (!ovf) begin
         return v[SCORE_BITS-1:0];
      end
      return v[SUM_BITS-1] ? SCORE_MIN : SCORE_MAX;
   endfunction

endpackage

// File: sv/tpaac_csr.sv
`timescale 1ns / 1ps
// ============================================================================
// tpaac_csr
// Scoring weight registers, written through a plain indexed write port.
// ============================================================================
module tpaac_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tpaac_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tpaac_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output tpaac_pkg::cfg_type                   cfg
);

   tpaac_pkg::cfg_type cfg_ff;
   tpaac_pkg::cfg_type cfg_in;

   // Index decode; out-of-range writes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (tpaac_pkg::csr_index_type'(csr_index))
            tpaac_pkg::CSR_MATCH:      cfg_in.match_score          = csr_wdata;
            tpaac_pkg::CSR_MISMATCH:   cfg_in.mismatch_score       = csr_wdata;
            tpaac_pkg::CSR_SHORT_STEP: cfg_in.short_gap_step       = csr_wdata;
            tpaac_pkg::CSR_SHORT_OPEN: cfg_in.short_gap_open_extra = csr_wdata;
            tpaac_pkg::CSR_LONG_STEP:  cfg_in.long_gap_step        = csr_wdata;
            tpaac_pkg::CSR_LONG_OPEN:  cfg_in.long_gap_open_extra  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_score          <= tpaac_pkg::MATCH_RESET;
         cfg_ff.mismatch_score       <= tpaac_pkg::MISMATCH_RESET;
         cfg_ff.short_gap_step       <= tpaac_pkg::SHORT_STEP_RESET;
         cfg_ff.short_gap_open_extra <= tpaac_pkg::SHORT_OPEN_RESET;
         cfg_ff.long_gap_step        <= tpaac_pkg::LONG_STEP_RESET;
         cfg_ff.long_gap_open_extra  <= tpaac_pkg::LONG_OPEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/tpaac_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// tpaac_cell
// Combinational cell: five layer scores, traceback code and best tracking.
// ============================================================================
module tpaac_cell (
   input  tpaac_pkg::cfg_type   cfg,
   input  tpaac_pkg::req_type   req,
   input  tpaac_pkg::best_type  best_cur,
   output tpaac_pkg::best_type  best_next,
   output tpaac_pkg::rsp_type   rsp
);

   localparam tpaac_pkg::idx_type ROW_LAST =
      tpaac_pkg::IDX_BITS'(tpaac_pkg::MAX_QUERY_LEN - 1);
   localparam tpaac_pkg::idx_type COL_LAST =
      tpaac_pkg::IDX_BITS'(tpaac_pkg::MAX_REF_LEN - 1);

   tpaac_pkg::score_type ins_o, ins_e, del_o, del_e;
   tpaac_pkg::score_type lins_o, lins_e, ldel_o, ldel_e;
   tpaac_pkg::score_type ins, del, lins, ldel, diag, m;
   tpaac_pkg::weight_type sub_weight;
   tpaac_pkg::idx_type    row_clamped, col_clamped;
   logic                  ins_open, del_open;
   logic [1:0]            dir;

   // Open and extend candidates, each saturated once
   always_comb begin
      ins_o  = tpaac_pkg::sat_score(tpaac_pkg::add3(req.left_match,
                  cfg.short_gap_step, cfg.short_gap_open_extra));
      ins_e  = tpaac_pkg::sat_score(tpaac_pkg::add3(req.left_insert,
                  cfg.short_gap_step, 8'sd0));
      del_o  = tpaac_pkg::sat_score(tpaac_pkg::add3(req.up_match,
                  cfg.short_gap_step, cfg.short_gap_open_extra));
      del_e  = tpaac_pkg::sat_score(tpaac_pkg::add3(req.up_delete,
                  cfg.short_gap_step, 8'sd0));
      lins_o = tpaac_pkg::sat_score(tpaac_pkg::add3(req.left_match,
                  cfg.long_gap_step, cfg.long_gap_open_extra));
      lins_e = tpaac_pkg::sat_score(tpaac_pkg::add3(req.left_long_insert,
                  cfg.long_gap_step, 8'sd0));
      ldel_o = tpaac_pkg::sat_score(tpaac_pkg::add3(req.up_match,
                  cfg.long_gap_step, cfg.long_gap_open_extra));
      ldel_e = tpaac_pkg::sat_score(tpaac_pkg::add3(req.up_long_delete,
                  cfg.long_gap_step, 8'sd0));
   end

   // Gap layers: ties go to extend
   always_comb begin
      ins_open = ins_o > ins_e;
      del_open = del_o > del_e;
      ins      = ins_open ? ins_o : ins_e;
      del      = del_open ? del_o : del_e;
      lins     = (lins_o > lins_e) ? lins_o : lins_e;
      ldel     = (ldel_o > ldel_e) ? ldel_o : ldel_e;
   end

   // Diagonal and five-way maximum
   always_comb begin
      sub_weight = (req.query_symbol == req.reference_symbol) ?
                   cfg.match_score : cfg.mismatch_score;
      diag = tpaac_pkg::sat_score(tpaac_pkg::add3(req.diag_match, sub_weight, 8'sd0));
      m = ins;
      if (del > m) begin
         m = del;
      end
      if (lins > m) begin
         m = lins;
      end
      if (ldel > m) begin
         m = ldel;
      end
      if (diag > m) begin
         m = diag;
      end
   end

   // Traceback direction: insert first, then delete, else diagonal
   always_comb begin
      if (m == ins) begin
         dir = tpaac_pkg::TRACE_LEFT;
      end else if (m == del) begin
         dir = tpaac_pkg::TRACE_UP;
      end else begin
         dir = tpaac_pkg::TRACE_DIAG;
      end
   end

   // Best tracker compare-select
   always_comb begin
      row_clamped = (32'(req.row_index) < tpaac_pkg::MAX_QUERY_LEN) ?
                    req.row_index : ROW_LAST;
      col_clamped = (32'(req.col_index) < tpaac_pkg::MAX_REF_LEN) ?
                    req.col_index : COL_LAST;
      best_next = best_cur;
      case (tpaac_pkg::cmd_type'(req.cmd))
         tpaac_pkg::CMD_CLEAR_BEST: begin
            best_next.value = tpaac_pkg::SCORE_MIN;
            best_next.row   = '0;
            best_next.col   = '0;
         end
         tpaac_pkg::CMD_UPDATE_BEST: begin
            if (m > best_cur.value) begin
               best_next.value = m;
               best_next.row   = row_clamped;
               best_next.col   = col_clamped;
            end
         end
         default: ;
      endcase
   end

   // Result assembly
   always_comb begin
      rsp.insert_score      = ins;
      rsp.match_layer_score = m;
      rsp.delete_score      = del;
      rsp.long_insert_score = lins;
      rsp.long_delete_score = ldel;
      rsp.trace_code        = '0;
      rsp.trace_code[1:0]   = dir;
      rsp.trace_code[tpaac_pkg::TRACE_IEXT_BIT] = ~ins_open;
      rsp.trace_code[tpaac_pkg::TRACE_DEXT_BIT] = ~del_open;
      rsp.best_score        = best_next.value;
      rsp.best_row          = best_next.row;
      rsp.best_col          = best_next.col;
   end

endmodule

// File: sv/two_piece_affine_align_cell.sv
// Pipeline: a request is held in the input register, then its result in the
//   result register, from which it transfers out.
// Throughput: one cell per cycle unless the result is stalled; the cell datapath
//   is a single pass of saturating adds and compares between the two registers.
// Reset: weights return to defaults, best score to most negative at (0,0),
//   and both pipeline stages empty.
`timescale 1ns / 1ps
// ============================================================================
// two_piece_affine_align_cell
// One cell of a five-layer two-piece affine alignment matrix per transfer.
// ============================================================================
module two_piece_affine_align_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpaac_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpaac_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [tpaac_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tpaac_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   tpaac_pkg::cfg_type  cfg;
   tpaac_pkg::req_type  req_ff;
   tpaac_pkg::rsp_type  rsp_ff;
   tpaac_pkg::rsp_type  rsp_in;
   tpaac_pkg::best_type best_ff;
   tpaac_pkg::best_type best_in;
   logic                req_valid_ff, req_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic                req_take;

   tpaac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpaac_cell u_cell (
      .cfg       (cfg),
      .req       (req_ff),
      .best_cur  (best_ff),
      .best_next (best_in),
      .rsp       (rsp_in)
   );

   // Stage handshake: the input stage moves whenever the result slot is free
   always_comb begin
      advance      = ~rsp_valid_ff | ~rsp_stall;
      req_stall    = req_valid_ff & ~advance;
      req_take     = req_valid & ~req_stall;
      req_valid_in = req_take | (req_valid_ff & ~advance);
      rsp_valid_in = (req_valid_ff & advance) | (rsp_valid_ff & ~advance);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_ff.value <= tpaac_pkg::SCORE_MIN;
         best_ff.row   <= '0;
         best_ff.col   <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_valid_ff && advance) begin
            best_ff <= best_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (req_valid_ff && advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the two-piece affine alignment cell. Cells are
// queued by a stimulus process and sent by a clocked driver; every accepted
// cell is scored by a local predictor and the result checked by a clocked
// monitor. Weight sets change between phases while the block is idle.
// ============================================================================
module testbench;
   import tpaac_pkg::*;

   localparam int unsigned STALL_LIMIT  = 400;  // cycles with no transfer at all
   localparam int unsigned PHASES       = 12;
   localparam int unsigned PHASE_CELLS  = 145;
   localparam int unsigned DRAIN_CYCLES = 3;    // settle time after the queues empty

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // Cells waiting to be sent, results waiting to come back
   req_type       cells_to_send [$];
   rsp_type       cells_awaited [$];

   // Predictor copy of the weights and the best-score tracker
   weight_type    weights [6];
   weight_type    staged_weights [6];
   score_type     best_score_q;
   idx_type       best_row_q;
   idx_type       best_col_q;

   bit            req_calm;
   bit            rsp_calm;
   int unsigned   req_wait;
   int unsigned   rsp_wait;
   int unsigned   idle_cycles;
   int unsigned   error_count;

   two_piece_affine_align_cell u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic score_type clamp_score(int v);
      if (v > int'(SCORE_MAX)) begin
         return SCORE_MAX;
      end
      if (v < int'(SCORE_MIN)) begin
         return SCORE_MIN;
      end
      return score_type'(v);
   endfunction

   // Score one cell and advance the best-score tracker
   function automatic rsp_type score_cell(req_type c);
      int        s_step, s_open, l_step, l_open, hit;
      int        ins_o, ins_e, del_o, del_e, li_o, li_e, ld_o, ld_e;
      int        ins, del, li, ld, dg, m;
      bit        ins_open, del_open;
      logic [1:0] dir;
      rsp_type   r;
      s_step = weights[CSR_SHORT_STEP];
      s_open = weights[CSR_SHORT_OPEN];
      l_step = weights[CSR_LONG_STEP];
      l_open = weights[CSR_LONG_OPEN];
      hit    = (c.query_symbol == c.reference_symbol) ? int'(weights[CSR_MATCH])
                                                      : int'(weights[CSR_MISMATCH]);
      ins_o = clamp_score(int'(c.left_match) + s_step + s_open);
      ins_e = clamp_score(int'(c.left_insert) + s_step);
      del_o = clamp_score(int'(c.up_match) + s_step + s_open);
      del_e = clamp_score(int'(c.up_delete) + s_step);
      li_o  = clamp_score(int'(c.left_match) + l_step + l_open);
      li_e  = clamp_score(int'(c.left_long_insert) + l_step);
      ld_o  = clamp_score(int'(c.up_match) + l_step + l_open);
      ld_e  = clamp_score(int'(c.up_long_delete) + l_step);
      // ties go to extend
      ins_open = ins_o > ins_e;
      del_open = del_o > del_e;
      ins = ins_open ? ins_o : ins_e;
      del = del_open ? del_o : del_e;
      li  = (li_o > li_e) ? li_o : li_e;
      ld  = (ld_o > ld_e) ? ld_o : ld_e;
      dg  = clamp_score(int'(c.diag_match) + hit);
      m = ins;
      if (del > m) m = del;
      if (li > m) m = li;
      if (ld > m) m = ld;
      if (dg > m) m = dg;
      // left wins over up; long layers report as diagonal
      if (m == ins) begin
         dir = TRACE_LEFT;
      end else if (m == del) begin
         dir = TRACE_UP;
      end else begin
         dir = TRACE_DIAG;
      end
      if (cmd_type'(c.cmd) == CMD_CLEAR_BEST) begin
         best_score_q = SCORE_MIN;
         best_row_q   = '0;
         best_col_q   = '0;
      end else if (cmd_type'(c.cmd) == CMD_UPDATE_BEST && m > int'(best_score_q)) begin
         best_score_q = score_type'(m);
         best_row_q   = (c.row_index < MAX_QUERY_LEN) ? c.row_index : idx_type'(MAX_QUERY_LEN - 1);
         best_col_q   = (c.col_index < MAX_REF_LEN) ? c.col_index : idx_type'(MAX_REF_LEN - 1);
      end
      r.insert_score      = score_type'(ins);
      r.match_layer_score = score_type'(m);
      r.delete_score      = score_type'(del);
      r.long_insert_score = score_type'(li);
      r.long_delete_score = score_type'(ld);
      r.trace_code        = {~del_open, ~ins_open, dir};
      r.best_score        = best_score_q;
      r.best_row          = best_row_q;
      r.best_col          = best_col_q;
      return r;
   endfunction

   // Cell with every score set to one value
   function automatic req_type flat_cell(cmd_type op, score_type v);
      req_type c;
      c.cmd              = op;
      c.query_symbol     = '0;
      c.reference_symbol = '0;
      c.left_insert      = v;
      c.left_match       = v;
      c.left_long_insert = v;
      c.up_match         = v;
      c.up_delete        = v;
      c.up_long_delete   = v;
      c.diag_match       = v;
      c.row_index        = '0;
      c.col_index        = '0;
      return c;
   endfunction

   // 0 full range, 1 clustered around a base, else near the rails
   function automatic score_type pick_score(int style, int base);
      case (style)
         0: return score_type'($urandom);
         1: return clamp_score(base + int'($urandom_range(0, 48)) - 24);
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               return clamp_score(int'(SCORE_MAX) - int'($urandom_range(0, 200)));
            end
            return clamp_score(int'(SCORE_MIN) + int'($urandom_range(0, 200)));
         end
      endcase
   endfunction

   function automatic req_type make_cell();
      req_type     c;
      int          style, base;
      int unsigned pick;
      pick  = $urandom_range(0, 9);
      style = (pick < 2) ? 0 : (pick < 8) ? 1 : 2;
      base  = int'($urandom_range(0, 4000)) - 2000;
      pick  = $urandom_range(0, 99);
      c.cmd = (pick < 40) ? CMD_UPDATE_BEST :
              (pick < 78) ? CMD_COMPUTE :
              (pick < 92) ? CMD_RESERVED : CMD_CLEAR_BEST;
      c.query_symbol     = SYM_BITS'($urandom);
      c.reference_symbol = ($urandom_range(0, 1) == 0) ? c.query_symbol
                                                       : SYM_BITS'($urandom);
      c.left_insert      = pick_score(style, base);
      c.left_match       = pick_score(style, base);
      c.left_long_insert = pick_score(style, base);
      c.up_match         = pick_score(style, base);
      c.up_delete        = pick_score(style, base);
      c.up_long_delete   = pick_score(style, base);
      c.diag_match       = pick_score(style, base);
      c.row_index        = IDX_BITS'($urandom);
      c.col_index        = IDX_BITS'($urandom);
      // open and extend tied
      if ($urandom_range(0, 5) == 0) begin
         c.left_insert = clamp_score(int'(c.left_match) + int'(weights[CSR_SHORT_OPEN]));
      end
      if ($urandom_range(0, 5) == 0) begin
         c.up_delete = clamp_score(int'(c.up_match) + int'(weights[CSR_SHORT_OPEN]));
      end
      if ($urandom_range(0, 5) == 0) begin
         c.left_long_insert = clamp_score(int'(c.left_match) + int'(weights[CSR_LONG_OPEN]));
      end
      if ($urandom_range(0, 5) == 0) begin
         c.up_long_delete = clamp_score(int'(c.up_match) + int'(weights[CSR_LONG_OPEN]));
      end
      // insert and delete tied
      if ($urandom_range(0, 7) == 0) begin
         c.up_match  = c.left_match;
         c.up_delete = c.left_insert;
      end
      return c;
   endfunction

   task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Write all staged weights back to back, then take them into the predictor
   task automatic load_weights();
      csr_index_type idx;
      idx = idx.first();
      do begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= staged_weights[idx];
         idx = idx.next();
      end while (idx != idx.first());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      weights = staged_weights;
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (cells_to_send.size() != 0 || req_valid || cells_awaited.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: sends queued cells, with a drawn gap after each
   always @(posedge clock) begin : drive_proc
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            cells_awaited.push_back(score_cell(req_data));
         end
         if (fire || !req_valid) begin
            if (req_wait != 0) begin
               req_valid <= 1'b0;
               req_wait  <= req_wait - 1;
            end else if (cells_to_send.size() != 0) begin
               req_data  <= cells_to_send.pop_front();
               req_valid <= 1'b1;
               req_wait  <= req_calm ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer, then stalls for a drawn count
   always @(posedge clock) begin : watch_proc
      rsp_type     want;
      int unsigned pause;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (cells_awaited.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            want = cells_awaited.pop_front();
            check_field("insert_score", want.insert_score, rsp_data.insert_score);
            check_field("match_layer_score", want.match_layer_score,
                        rsp_data.match_layer_score);
            check_field("delete_score", want.delete_score, rsp_data.delete_score);
            check_field("long_insert_score", want.long_insert_score,
                        rsp_data.long_insert_score);
            check_field("long_delete_score", want.long_delete_score,
                        rsp_data.long_delete_score);
            check_field("trace_code", want.trace_code, rsp_data.trace_code);
            check_field("best_score", want.best_score, rsp_data.best_score);
            check_field("best_row", want.best_row, rsp_data.best_row);
            check_field("best_col", want.best_col, rsp_data.best_col);
         end
         pause = rsp_calm ? 0 : $urandom_range(0, 3);
         rsp_stall <= (pause != 0);
         rsp_wait  <= pause;
      end else if (rsp_wait != 0) begin
         rsp_stall <= (rsp_wait != 1);
         rsp_wait  <= rsp_wait - 1;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed cells at reset weights, then random phases
   initial begin
      req_type c;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_wait    = 0;
      rsp_wait    = 0;
      idle_cycles = 0;
      error_count = 0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      weights[CSR_MATCH]      = MATCH_RESET;
      weights[CSR_MISMATCH]   = MISMATCH_RESET;
      weights[CSR_SHORT_STEP] = SHORT_STEP_RESET;
      weights[CSR_SHORT_OPEN] = SHORT_OPEN_RESET;
      weights[CSR_LONG_STEP]  = LONG_STEP_RESET;
      weights[CSR_LONG_OPEN]  = LONG_OPEN_RESET;
      best_score_q = SCORE_MIN;
      best_row_q   = '0;
      best_col_q   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero cell, then saturation at both rails
      cells_to_send.push_back(flat_cell(CMD_COMPUTE, '0));
      c = flat_cell(CMD_UPDATE_BEST, SCORE_MAX);
      c.query_symbol = 8'hFF; c.reference_symbol = 8'hFF;
      c.row_index = '1; c.col_index = '1;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_UPDATE_BEST, SCORE_MIN);
      c.reference_symbol = 8'hFF;
      cells_to_send.push_back(c);
      // clear, then an update from the most negative scores
      cells_to_send.push_back(flat_cell(CMD_CLEAR_BEST, SCORE_MIN));
      c = flat_cell(CMD_UPDATE_BEST, SCORE_MIN);
      c.row_index = 10'd5; c.col_index = 10'd7;
      cells_to_send.push_back(c);
      // insert open ties extend
      c = flat_cell(CMD_COMPUTE, -16'sd1000);
      c.left_match = '0; c.left_insert = -16'sd4;
      cells_to_send.push_back(c);
      // left, up (equal best, no update) and diagonal maxima
      c = flat_cell(CMD_UPDATE_BEST, -16'sd1000);
      c.left_match = 16'sd300; c.row_index = 10'd3; c.col_index = 10'd4;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_UPDATE_BEST, -16'sd1000);
      c.up_match = 16'sd300; c.row_index = 10'd8; c.col_index = 10'd8;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_UPDATE_BEST, -16'sd1000);
      c.diag_match = 16'sd400; c.query_symbol = 8'd9; c.reference_symbol = 8'd9;
      c.row_index = 10'd11; c.col_index = 10'd12;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_COMPUTE, -16'sd1000);
      c.diag_match = 16'sd400; c.query_symbol = 8'd1; c.reference_symbol = 8'd2;
      cells_to_send.push_back(c);
      // long layers carry the maximum
      c = flat_cell(CMD_COMPUTE, -16'sd1000);
      c.left_long_insert = 16'sd500;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_COMPUTE, -16'sd1000);
      c.up_long_delete = 16'sd500;
      cells_to_send.push_back(c);
      // insert and delete tied at the maximum
      c = flat_cell(CMD_COMPUTE, -16'sd1000);
      c.left_match = 16'sd300; c.up_match = 16'sd300;
      cells_to_send.push_back(c);
      // unused command leaves the best alone
      c = flat_cell(CMD_RESERVED, 16'sd1000);
      c.diag_match = 16'sd5000; c.row_index = 10'd9; c.col_index = 10'd9;
      cells_to_send.push_back(c);
      c = flat_cell(CMD_UPDATE_BEST, -16'sd1);
      c.query_symbol = 8'hFF; c.reference_symbol = 8'hFF;
      c.row_index = 10'd1023; c.col_index = 10'd1022;
      cells_to_send.push_back(c);
      cells_to_send.push_back(flat_cell(CMD_CLEAR_BEST, 16'sd77));
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: foreach (staged_weights[i]) staged_weights[i] = -8'sd128;
            1: foreach (staged_weights[i]) staged_weights[i] = 8'sd127;
            2: begin
               staged_weights[CSR_MATCH]      = 8'sd127;
               staged_weights[CSR_MISMATCH]   = -8'sd128;
               staged_weights[CSR_SHORT_STEP] = -8'sd128;
               staged_weights[CSR_SHORT_OPEN] = 8'sd127;
               staged_weights[CSR_LONG_STEP]  = 8'sd127;
               staged_weights[CSR_LONG_OPEN]  = -8'sd128;
            end
            3: foreach (staged_weights[i]) staged_weights[i] = '0;
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  // typical scoring: reward matches, penalize gaps
                  staged_weights[CSR_MATCH]      = weight_type'($urandom_range(1, 8));
                  staged_weights[CSR_MISMATCH]   = weight_type'(-$urandom_range(1, 8));
                  staged_weights[CSR_SHORT_STEP] = weight_type'(-$urandom_range(1, 4));
                  staged_weights[CSR_SHORT_OPEN] = weight_type'(-$urandom_range(0, 12));
                  staged_weights[CSR_LONG_STEP]  = weight_type'(-$urandom_range(0, 2));
                  staged_weights[CSR_LONG_OPEN]  = weight_type'(-$urandom_range(8, 40));
               end else begin
                  foreach (staged_weights[i]) staged_weights[i] = weight_type'($urandom);
               end
            end
         endcase
         load_weights();
         @(negedge clock);
         req_calm = (p % 4 == 1);
         rsp_calm = (p % 4 == 2);
         for (int n = 0; n < PHASE_CELLS; n++) begin
            cells_to_send.push_back(make_cell());
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
